@@ design/gepd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gepd_pkg
// Beat types and constants shared by the grid energy path datapath.
// ----------------------------------------------------------------------------
package gepd_pkg;

   localparam int ENERGY_W  = 32;
   localparam int GAIN_W    = 17;
   localparam int COST_W    = 16;
   localparam int SIDE_W    = 6;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
   localparam logic [SIDE_W-1:0]   SIDE_RESET = 6'd32;

   typedef struct packed {
      logic signed [GAIN_W-1:0] cell_gain;
      logic [COST_W-1:0]        cost_from_left;
      logic [COST_W-1:0]        cost_from_above;
   } req_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] cell_energy;
      logic                reachable;
      logic                last_cell;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic [ENERGY_W-1:0] energy;
   } cell_type;

   typedef struct packed {
      logic first_row;
      logic first_col;
   } pos_type;

endpackage

@@ design/gepd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gepd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gepd_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/gepd_cell_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gepd_cell_calc
// Energy of one cell from its left and upper neighbours, saturating.
// ----------------------------------------------------------------------------
module gepd_cell_calc (
   input  gepd_pkg::req_type  item,
   input  gepd_pkg::pos_type  pos,
   input  gepd_pkg::cell_type left,
   input  gepd_pkg::cell_type above,
   output gepd_pkg::cell_type cur
);

   logic                              blocked;
   logic [gepd_pkg::COST_W-1:0]       gain;
   logic                              ok_left;
   logic                              ok_above;
   logic [gepd_pkg::ENERGY_W:0]       sum_left;
   logic [gepd_pkg::ENERGY_W:0]       sum_above;
   logic [gepd_pkg::ENERGY_W-1:0]     val_left;
   logic [gepd_pkg::ENERGY_W-1:0]     val_above;

   assign blocked = item.cell_gain[gepd_pkg::GAIN_W-1];
   assign gain    = item.cell_gain[gepd_pkg::COST_W-1:0];

   assign ok_left  = !pos.first_col && left.valid &&
                     (left.energy >= gepd_pkg::ENERGY_W'(item.cost_from_left));
   assign ok_above = !pos.first_row && above.valid &&
                     (above.energy >= gepd_pkg::ENERGY_W'(item.cost_from_above));

   assign sum_left  = {1'b0, left.energy - gepd_pkg::ENERGY_W'(item.cost_from_left)}
                      + (gepd_pkg::ENERGY_W + 1)'(gain);
   assign sum_above = {1'b0, above.energy - gepd_pkg::ENERGY_W'(item.cost_from_above)}
                      + (gepd_pkg::ENERGY_W + 1)'(gain);

   assign val_left  = sum_left[gepd_pkg::ENERGY_W] ? gepd_pkg::ENERGY_MAX
                                                   : sum_left[gepd_pkg::ENERGY_W-1:0];
   assign val_above = sum_above[gepd_pkg::ENERGY_W] ? gepd_pkg::ENERGY_MAX
                                                    : sum_above[gepd_pkg::ENERGY_W-1:0];

   always_comb begin
      cur.valid  = 1'b0;
      cur.energy = '0;
      if (!blocked) begin
         if (pos.first_row && pos.first_col) begin
            cur.valid  = 1'b1;
            cur.energy = gepd_pkg::ENERGY_W'(gain);
         end else if (ok_left && ok_above) begin
            cur.valid  = 1'b1;
            cur.energy = (val_above > val_left) ? val_above : val_left;
         end else if (ok_left) begin
            cur.valid  = 1'b1;
            cur.energy = val_left;
         end else if (ok_above) begin
            cur.valid  = 1'b1;
            cur.energy = val_above;
         end
      end
   end

endmodule

@@ design/grid_energy_path_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_energy_path_dp
// Best-energy path through a square grid, one cell per beat in row-major order.
//
// req_*: one beat per cell (gain, left edge cost, upper edge cost), taken
//   when req_valid is high and req_stall low.
// rsp_*: one beat per cell (energy, reachable, last cell flag), taken when
//   rsp_valid is high and rsp_stall low; the bottom-right cell carries the answer.
// csr_*: writes the grid side; a write restarts the grid at the top-left cell.
//   Write only while no cell is in flight.
// A request beat passes the input register, then the response register; one
// cell is taken every cycle while rsp_stall is low: the previous row sits in a
// RAM read at the cell's column as the request beat is taken, with a bypass when
// the cell just above was the beat before. If rsp_stall holds, one cell waits in
// the response register and one in the input register, then req_stall rises.
// Reset empties both registers, sets the side to 32 and the position to the
// top-left cell.
// ----------------------------------------------------------------------------
module grid_energy_path_dp #(
   parameter int MAX_SIDE = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  gepd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output gepd_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gepd_pkg::SIDE_W-1:0]      csr_data
);

   localparam int IDX_W = $clog2(MAX_SIDE);
   localparam int EFF_W = $clog2(MAX_SIDE + 1);

   logic [gepd_pkg::SIDE_W-1:0] side_ff;
   logic [EFF_W-1:0]            eff_side;
   logic [EFF_W-1:0]            side_m1;

   logic [IDX_W-1:0]            col_ff,  col_in;
   logic [IDX_W-1:0]            row_ff,  row_in;
   logic                        col_last;
   logic                        row_last;

   logic                        s1_valid_ff, s1_valid_in;
   gepd_pkg::req_type           s1_item_ff;
   gepd_pkg::pos_type           s1_pos_ff;
   logic                        s1_last_ff;
   logic [IDX_W-1:0]            s1_col_ff;
   logic                        fwd_ff;
   gepd_pkg::cell_type          fwd_val_ff;

   gepd_pkg::cell_type          left_ff;
   gepd_pkg::cell_type          above;
   gepd_pkg::cell_type          ram_rd;
   gepd_pkg::cell_type          cur;
   gepd_pkg::pos_type           pos_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   gepd_pkg::rsp_type           rsp_ff;

   logic                        accept;
   logic                        advance;
   logic                        csr_write;

   // side in use
   always_comb begin
      if (side_ff == '0) begin
         eff_side = EFF_W'(1);
      end else if (32'(side_ff) > 32'(MAX_SIDE)) begin
         eff_side = EFF_W'(MAX_SIDE);
      end else begin
         eff_side = EFF_W'(side_ff);
      end
   end

   assign side_m1  = eff_side - EFF_W'(1);
   assign col_last = (EFF_W'(col_ff) == side_m1);
   assign row_last = (EFF_W'(row_ff) == side_m1);

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = !s1_valid_ff;
   assign csr_write = csr_valid && csr_ready;

   assign pos_in.first_row = (row_ff == '0);
   assign pos_in.first_col = (col_ff == '0);

   // position of the next request beat
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + IDX_W'(1);
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end
   end

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff       <= gepd_pkg::SIDE_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         left_ff.valid <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            side_ff       <= csr_data;
            left_ff.valid <= 1'b0;
         end else if (advance) begin
            left_ff.valid  <= cur.valid;
            left_ff.energy <= cur.energy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
         s1_pos_ff  <= pos_in;
         s1_last_ff <= col_last && row_last;
         s1_col_ff  <= col_ff;
         fwd_ff     <= advance && (s1_col_ff == col_ff);
         fwd_val_ff <= cur;
      end
      if (advance) begin
         rsp_ff.cell_energy  <= cur.valid ? cur.energy : '0;
         rsp_ff.reachable    <= cur.valid;
         rsp_ff.last_cell    <= s1_last_ff;
      end
   end

   gepd_ram #(
      .WIDTH ($bits(gepd_pkg::cell_type)),
      .DEPTH (MAX_SIDE)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (cur),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd)
   );

   assign above = fwd_ff ? fwd_val_ff : ram_rd;

   gepd_cell_calc u_calc (
      .item  (s1_item_ff),
      .pos   (s1_pos_ff),
      .left  (left_ff),
      .above (above),
      .cur   (cur)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/grid_energy_path_dp_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_energy_path_dp_test
// Self-checking bench for the grid energy path datapath. Cells are streamed
// in row-major order over a range of grid sides, including the out-of-range
// side codes and a restart part-way through a grid. A behavioural model of
// the best-energy recurrence predicts each response beat, which is compared
// field by field in order. Both channels idle and stall at random, and the
// response side is held off for a long stretch so the input backs up.
// ----------------------------------------------------------------------------
module grid_energy_path_dp_test;

   localparam int MAX_SIDE    = 32;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASES      = 10;

   class energy_scoreboard;
      gepd_pkg::cell_type          above_row [MAX_SIDE];
      gepd_pkg::cell_type          left_cell;
      int unsigned                 row_pos;
      int unsigned                 col_pos;
      logic [gepd_pkg::SIDE_W-1:0] side_reg;
      gepd_pkg::rsp_type           expected_q [$];
      int                          mismatches;

      function new();
         foreach (above_row[i]) above_row[i] = '0;
         left_cell  = '0;
         row_pos    = 0;
         col_pos    = 0;
         side_reg   = gepd_pkg::SIDE_RESET;
         mismatches = 0;
      endfunction

      function void note_side(logic [gepd_pkg::SIDE_W-1:0] value);
         side_reg  = value;
         row_pos   = 0;
         col_pos   = 0;
         left_cell = '0;
      endfunction

      // entry over one edge, kept only when it leaves the best remainder
      function void try_edge(gepd_pkg::cell_type nb, logic [gepd_pkg::COST_W-1:0] cost,
                             logic [gepd_pkg::COST_W-1:0] gain,
                             inout gepd_pkg::cell_type best);
         logic [gepd_pkg::ENERGY_W:0]   total;
         logic [gepd_pkg::ENERGY_W-1:0] sat;
         if (!nb.valid || nb.energy < gepd_pkg::ENERGY_W'(cost)) return;
         total = {1'b0, nb.energy - gepd_pkg::ENERGY_W'(cost)}
                 + (gepd_pkg::ENERGY_W + 1)'(gain);
         sat   = total[gepd_pkg::ENERGY_W] ? gepd_pkg::ENERGY_MAX
                                           : total[gepd_pkg::ENERGY_W-1:0];
         if (!best.valid || sat > best.energy) begin
            best.valid  = 1'b1;
            best.energy = sat;
         end
      endfunction

      function void note_cell(gepd_pkg::req_type item_in);
         int unsigned        side;
         gepd_pkg::cell_type best;
         gepd_pkg::rsp_type  beat;
         side = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
         if (row_pos >= side) row_pos = 0;
         if (col_pos >= side) col_pos = 0;
         best = '0;
         if (!item_in.cell_gain[gepd_pkg::GAIN_W-1]) begin
            if (row_pos == 0 && col_pos == 0) begin
               best.valid  = 1'b1;
               best.energy = gepd_pkg::ENERGY_W'(item_in.cell_gain[gepd_pkg::COST_W-1:0]);
            end else begin
               if (col_pos > 0)
                  try_edge(left_cell, item_in.cost_from_left,
                           item_in.cell_gain[gepd_pkg::COST_W-1:0], best);
               if (row_pos > 0)
                  try_edge(above_row[col_pos], item_in.cost_from_above,
                           item_in.cell_gain[gepd_pkg::COST_W-1:0], best);
            end
         end
         above_row[col_pos] = best;
         left_cell          = best;
         beat.cell_energy   = best.valid ? best.energy : '0;
         beat.reachable     = best.valid;
         beat.last_cell     = (row_pos == side - 1) && (col_pos == side - 1);
         expected_q         = {expected_q, beat};
         if (col_pos + 1 >= side) begin
            col_pos   = 0;
            left_cell = '0;
            row_pos   = (row_pos + 1 >= side) ? 0 : row_pos + 1;
         end else begin
            col_pos = col_pos + 1;
         end
      endfunction

      function void check(gepd_pkg::rsp_type got);
         gepd_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response beat with nothing expected: energy %0d reach %0b last %0b",
                        got.cell_energy, got.reachable, got.last_cell);
            return;
         end
         want = expected_q.pop_front();
         if (got.cell_energy !== want.cell_energy || got.reachable !== want.reachable ||
             got.last_cell !== want.last_cell) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected energy %0d reach %0b last %0b, got %0d %0b %0b",
                        want.cell_energy, want.reachable, want.last_cell,
                        got.cell_energy, got.reachable, got.last_cell);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   gepd_pkg::req_type           req_data  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   gepd_pkg::rsp_type           rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [gepd_pkg::SIDE_W-1:0] csr_data  = '0;

   energy_scoreboard  ledger;
   gepd_pkg::req_type cell_queue [$];
   int                sender_idle_pct   = 31;
   int                receiver_idle_pct = 60;
   bit                hold_request      = 1'b0;
   int                hold_left         = 0;
   int                quiet_cycles      = 0;

   int phase_side  [PHASES] = '{4, 2, 7, 32, 1, 45, 13, 0, 63, 5};
   int phase_cells [PHASES] = '{80, 40, 147, 200, 30, 1024, 169, 20, 100, 50};
   int phase_mode  [PHASES] = '{0, 0, 0, 0, 1, 1, 2, 2, 2, 2};

   grid_energy_path_dp #(
      .MAX_SIDE (MAX_SIDE)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // request side: note each accepted beat, then offer the next cell or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) ledger.note_cell(req_data);
         if (!req_valid || !req_stall) begin
            if (cell_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= cell_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side: check accepted beats, stall at random or for a long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.check(rsp_data);
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_cell(input logic signed [gepd_pkg::GAIN_W-1:0] gain,
                             input logic [gepd_pkg::COST_W-1:0] left_cost,
                             input logic [gepd_pkg::COST_W-1:0] above_cost);
      gepd_pkg::req_type entry;
      entry.cell_gain       = gain;
      entry.cost_from_left  = left_cost;
      entry.cost_from_above = above_cost;
      cell_queue            = {cell_queue, entry};
   endtask

   // mostly passable edges with random content, some blocked cells and noise
   task automatic queue_random_cell();
      int                                 pick;
      logic signed [gepd_pkg::GAIN_W-1:0] gain;
      logic [gepd_pkg::COST_W-1:0]        left_cost;
      logic [gepd_pkg::COST_W-1:0]        above_cost;
      pick = $urandom_range(99);
      if (pick < 6)
         gain = -17'sd1;
      else if (pick < 10)
         gain = gepd_pkg::GAIN_W'($urandom);
      else if (pick < 35)
         gain = gepd_pkg::GAIN_W'($urandom_range(255));
      else
         gain = gepd_pkg::GAIN_W'($urandom_range(65535));
      left_cost  = ($urandom_range(99) < 70) ? gepd_pkg::COST_W'($urandom_range(40000))
                                              : gepd_pkg::COST_W'($urandom);
      above_cost = ($urandom_range(99) < 70) ? gepd_pkg::COST_W'($urandom_range(40000))
                                              : gepd_pkg::COST_W'($urandom);
      queue_cell(gain, left_cost, above_cost);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (cell_queue.size() != 0 || req_valid || ledger.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_side(input logic [gepd_pkg::SIDE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      ledger.note_side(value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      ledger = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset side, then a restart part-way through the first row
      queue_cell(17'sd65535, 16'd0, 16'd0);
      queue_cell(17'sd0, 16'd65535, 16'd65535);
      queue_cell(17'sd1, 16'd0, 16'd0);
      wait_idle();
      write_side(6'd3);
      // zero-margin edge, refused edge, blocked and negative gains
      queue_cell(17'sd65535, 16'd65535, 16'd65535);
      queue_cell(17'sd0, 16'd65535, 16'd0);
      queue_cell(17'sd5, 16'd1, 16'd0);
      queue_cell(17'sd100, 16'd0, 16'd0);
      queue_cell(17'sd3, 16'd65535, 16'd0);
      queue_cell(-17'sd1, 16'd0, 16'd0);
      queue_cell(-17'sd65536, 16'd0, 16'd0);
      queue_cell(17'sd1, 16'd0, 16'd103);
      queue_cell(17'sd65535, 16'd1, 16'd0);
      // blocked start leaves the whole grid unreachable
      queue_cell(-17'sd1, 16'd0, 16'd0);
      repeat (8) queue_cell(17'sd65535, 16'd0, 16'd0);
      wait_idle();
      // side code zero behaves as a single cell
      write_side(6'd0);
      queue_cell(17'sd65535, 16'd65535, 16'd65535);
      queue_cell(-17'sd1, 16'd0, 16'd0);
      queue_cell(-17'sd43827, 16'd1234, 16'd4321);
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (phase_mode[p])
            0: begin
               sender_idle_pct   = 31;
               receiver_idle_pct = 60;
            end
            1: begin
               sender_idle_pct   = 60;
               receiver_idle_pct = 31;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         write_side(gepd_pkg::SIDE_W'(phase_side[p]));
         repeat (phase_cells[p]) queue_random_cell();
         if (p == 6) begin
            @(negedge clock);
            hold_request = 1'b1;
         end
         wait_idle();
      end

      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
